[hw/rtl/lmiou_pkg.sv]
// Shared types and constants for the label map IoU match counter.
// No dependencies; used by lmiou_match and label_map_iou_match_counter.
`default_nettype none
package lmiou_pkg;
    localparam int LABEL_W   = 6;
    localparam int MAX_LABEL = 63;
    localparam int COUNT_W   = 20;
    localparam int THR_W     = 16;
    localparam int NUM_THR   = 4;
    localparam int TIDX_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int OVL_AW    = 2 * LABEL_W;
    localparam int UNI_W     = COUNT_W + 1;
    localparam int PROD_W    = UNI_W + THR_W;

    localparam logic [CFG_IDX_W-1:0] REG_THR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_THREE = 3'd4;

    // Tag that follows one label pair down the histogram walk pipeline.
    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] j;
        logic               j_last;
    } walk_tag_t;
endpackage
`default_nettype wire

[hw/rtl/lmiou_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module lmiou_ram #(
    parameter int AW = 6,
    parameter int DW = 20
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/lmiou_match.sv]
// Overlap test for one label pair: union, threshold product, compare.
// Depends on lmiou_pkg.
`default_nettype none
module lmiou_match (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lmiou_pkg::walk_tag_t          tag_in,
    input  wire logic [lmiou_pkg::COUNT_W-1:0] inter,
    input  wire logic [lmiou_pkg::COUNT_W-1:0] ref_area,
    input  wire logic [lmiou_pkg::COUNT_W-1:0] pred_area,
    input  wire logic [lmiou_pkg::THR_W-1:0]   thr,
    output lmiou_pkg::walk_tag_t               tag_out,
    output logic                               match
);
    logic [lmiou_pkg::UNI_W-1:0]  sum;
    logic [lmiou_pkg::UNI_W-1:0]  uni;
    logic [lmiou_pkg::PROD_W-1:0] prod_next;
    logic [lmiou_pkg::PROD_W-1:0] prod_reg;
    logic [lmiou_pkg::COUNT_W-1:0] inter_reg;
    logic                         uni_zero_reg;
    lmiou_pkg::walk_tag_t         tag_reg;
    logic [lmiou_pkg::PROD_W-1:0] lhs;

    always_comb begin
        sum = {1'b0, ref_area} + {1'b0, pred_area};
        uni = (sum >= {1'b0, inter}) ? (sum - {1'b0, inter}) : '0;
        prod_next = lmiou_pkg::PROD_W'(thr) * lmiou_pkg::PROD_W'(uni);
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        inter_reg    <= inter;
        uni_zero_reg <= (uni == '0);
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag_in;
        end
    end

    always_comb begin
        lhs = lmiou_pkg::PROD_W'({inter_reg, 16'h0000});
        tag_out = tag_reg;
        match = tag_reg.valid && !uni_zero_reg && (lhs > prod_reg);
    end
endmodule
`default_nettype wire

[hw/rtl/label_map_iou_match_counter.sv]
// Label map IoU match counter: accumulate a pair histogram, then walk it per threshold.
// Throughput: one pixel word per cycle while s_tready is high (accumulate state only);
// each pixel's store words are read, then written back. After the last pixel: a drain
// state, then per threshold a walk over max_ref*max_pred pairs (one pair per cycle
// through the overlap RAM read port; none when either side is empty), then the result
// waits for m_tready. Reset and every image end clear all 4096 overlap RAM entries.
// Reset is synchronous, active low; registers return to threshold_count 1, thresholds 32768.
`default_nettype none
module label_map_iou_match_counter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // pixel stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [5:0] ref_label, [11:6] pred_label, rest zero
    input  wire logic        s_tlast,   // last_pixel
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [5:0] true_pos, [11:6] false_pos, [17:12] false_neg
    output logic [1:0]       m_tuser,   // threshold_index
    output logic             m_tlast    // last_result
);
    localparam int LW = lmiou_pkg::LABEL_W;
    localparam int CW = lmiou_pkg::COUNT_W;
    localparam int AW = lmiou_pkg::OVL_AW;
    localparam logic [CW-1:0] CNT_MAX = '1;
    localparam logic [LW-1:0] LBL_MAX = LW'(lmiou_pkg::MAX_LABEL);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_RES   = 3'd4;

    // configuration registers
    logic [2:0]  thr_count_reg;
    logic [15:0] thr_reg [lmiou_pkg::NUM_THR];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_count_reg <= 3'd1;
            for (int k = 0; k < lmiou_pkg::NUM_THR; k++) begin
                thr_reg[k] <= 16'h8000;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lmiou_pkg::REG_THR_COUNT: thr_count_reg <= cfg_wdata[2:0];
                lmiou_pkg::REG_THR_ZERO:  thr_reg[0] <= cfg_wdata;
                lmiou_pkg::REG_THR_ONE:   thr_reg[1] <= cfg_wdata;
                lmiou_pkg::REG_THR_TWO:   thr_reg[2] <= cfg_wdata;
                lmiou_pkg::REG_THR_THREE: thr_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective threshold count, clamped to 1..4
    logic [1:0] t_last_idx;
    always_comb begin
        if (thr_count_reg == 3'd0) begin
            t_last_idx = 2'd0;
        end else if (thr_count_reg > 3'd4) begin
            t_last_idx = 2'd3;
        end else begin
            t_last_idx = 2'(thr_count_reg - 3'd1);
        end
    end

    // control state
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [LW-1:0] max_ref_reg, max_pred_reg;
    logic [1:0]    t_reg;

    // accumulate stage: pixel whose store words are being read back
    logic          acc_v_reg;
    logic [LW-1:0] acc_r_reg, acc_p_reg;
    // last written word of each store, for back-to-back hits on the same entry
    logic          fw_o_v_reg, fw_r_v_reg, fw_p_v_reg;
    logic [AW-1:0] fw_o_a_reg;
    logic [LW-1:0] fw_r_a_reg, fw_p_a_reg;
    logic [CW-1:0] fw_o_d_reg, fw_r_d_reg, fw_p_d_reg;

    // walk state
    logic [LW-1:0] wi_reg, wj_reg;
    logic          issue_done_reg;
    lmiou_pkg::walk_tag_t p1_tag_reg, p2_tag;
    logic          p2_match;
    logic [1:0]    hits_reg;
    logic [LW-1:0] tp_reg, fn_reg;
    logic [lmiou_pkg::MAX_LABEL:0] pmatched_reg;
    logic [LW:0]   pm_cnt_reg;

    // output register
    logic          out_v_reg;
    logic [1:0]    out_idx_reg;
    logic [LW-1:0] out_tp_reg, out_fp_reg, out_fn_reg;
    logic          out_last_reg;

    // handshake and input fields
    logic          s_acc;
    logic [LW-1:0] in_ref, in_pred;
    assign in_ref   = s_tdata[5:0];
    assign in_pred  = s_tdata[11:6];
    assign s_tready = (state_reg == ST_ACC);
    assign s_acc    = s_tvalid && s_tready;

    // store ports
    logic          o_we, r_we, p_we;
    logic [AW-1:0] o_wa, o_ra;
    logic [LW-1:0] r_wa, p_wa, r_ra, p_ra;
    logic [CW-1:0] o_wd, r_wd, p_wd, o_rd, r_rd, p_rd;
    logic [CW-1:0] o_base, r_base, p_base;

    always_comb begin
        o_base = (fw_o_v_reg && fw_o_a_reg == {acc_r_reg, acc_p_reg}) ? fw_o_d_reg : o_rd;
        r_base = (fw_r_v_reg && fw_r_a_reg == acc_r_reg) ? fw_r_d_reg : r_rd;
        p_base = (fw_p_v_reg && fw_p_a_reg == acc_p_reg) ? fw_p_d_reg : p_rd;

        if (state_reg == ST_CLR) begin
            o_we = 1'b1;
            r_we = 1'b1;
            p_we = 1'b1;
            o_wa = clr_cnt_reg;
            r_wa = clr_cnt_reg[LW-1:0];
            p_wa = clr_cnt_reg[LW-1:0];
            o_wd = '0;
            r_wd = '0;
            p_wd = '0;
        end else begin
            o_we = acc_v_reg && acc_r_reg != '0 && acc_p_reg != '0;
            r_we = acc_v_reg && acc_r_reg != '0;
            p_we = acc_v_reg && acc_p_reg != '0;
            o_wa = {acc_r_reg, acc_p_reg};
            r_wa = acc_r_reg;
            p_wa = acc_p_reg;
            o_wd = (o_base == CNT_MAX) ? o_base : o_base + 1'b1;
            r_wd = (r_base == CNT_MAX) ? r_base : r_base + 1'b1;
            p_wd = (p_base == CNT_MAX) ? p_base : p_base + 1'b1;
        end

        if (state_reg == ST_WALK) begin
            o_ra = {wi_reg, wj_reg};
            r_ra = wi_reg;
            p_ra = wj_reg;
        end else begin
            o_ra = {in_ref, in_pred};
            r_ra = in_ref;
            p_ra = in_pred;
        end
    end

    lmiou_ram #(.AW(AW), .DW(CW)) u_ovl (
        .aclk(aclk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
    );
    lmiou_ram #(.AW(LW), .DW(CW)) u_ref_area (
        .aclk(aclk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd)
    );
    lmiou_ram #(.AW(LW), .DW(CW)) u_pred_area (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
    );

    // pair test for the current threshold
    logic [15:0] thr_sel;
    always_comb begin
        case (t_reg)
            2'd0:    thr_sel = thr_reg[0];
            2'd1:    thr_sel = thr_reg[1];
            2'd2:    thr_sel = thr_reg[2];
            default: thr_sel = thr_reg[3];
        endcase
    end

    lmiou_match u_match (
        .aclk(aclk), .aresetn(aresetn), .tag_in(p1_tag_reg),
        .inter(o_rd), .ref_area(r_rd), .pred_area(p_rd), .thr(thr_sel),
        .tag_out(p2_tag), .match(p2_match)
    );

    // walk bookkeeping
    logic          walk_empty;
    logic          walk_finish;
    logic          issue;
    logic [1:0]    hits_sum;
    logic [LW-1:0] fn_final;
    assign walk_empty  = (max_ref_reg == '0) || (max_pred_reg == '0);
    assign issue       = (state_reg == ST_WALK) && !issue_done_reg;
    assign walk_finish = (state_reg == ST_WALK) && issue_done_reg && !p1_tag_reg.valid
                         && !p2_tag.valid;
    assign hits_sum    = (hits_reg == 2'd2) ? 2'd2 : hits_reg + {1'b0, p2_match};
    // with no predicted labels every reference label goes unmatched
    assign fn_final    = (max_pred_reg == '0) ? max_ref_reg : fn_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:   if (clr_cnt_reg == '1) state_next = ST_ACC;
            ST_ACC:   if (s_acc && s_tlast) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_WALK;
            ST_WALK:  if (walk_finish) state_next = ST_RES;
            ST_RES: begin
                if (m_tready) begin
                    state_next = (t_reg == t_last_idx) ? ST_CLR : ST_WALK;
                end
            end
            default:  state_next = ST_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        // payload of the accumulate stage and forwarding words
        acc_r_reg <= in_ref;
        acc_p_reg <= in_pred;
        if (o_we) begin
            fw_o_a_reg <= o_wa;
            fw_o_d_reg <= o_wd;
        end
        if (r_we) begin
            fw_r_a_reg <= r_wa;
            fw_r_d_reg <= r_wd;
        end
        if (p_we) begin
            fw_p_a_reg <= p_wa;
            fw_p_d_reg <= p_wd;
        end
        if (walk_finish) begin
            out_idx_reg  <= t_reg;
            out_tp_reg   <= tp_reg;
            out_fn_reg   <= fn_final;
            out_fp_reg   <= max_pred_reg - pm_cnt_reg[LW-1:0];
            out_last_reg <= (t_reg == t_last_idx);
        end
        p1_tag_reg.j      <= wj_reg;
        p1_tag_reg.j_last <= (wj_reg == max_pred_reg);

        if (!aresetn) begin
            state_reg        <= ST_CLR;
            clr_cnt_reg      <= '0;
            max_ref_reg      <= '0;
            max_pred_reg     <= '0;
            t_reg            <= '0;
            acc_v_reg        <= 1'b0;
            fw_o_v_reg       <= 1'b0;
            fw_r_v_reg       <= 1'b0;
            fw_p_v_reg       <= 1'b0;
            p1_tag_reg.valid <= 1'b0;
            issue_done_reg   <= 1'b0;
            out_v_reg        <= 1'b0;
            wi_reg           <= '0;
            wj_reg           <= '0;
            hits_reg         <= '0;
            tp_reg           <= '0;
            fn_reg           <= '0;
            pmatched_reg     <= '0;
            pm_cnt_reg       <= '0;
        end else begin
            state_reg        <= state_next;
            acc_v_reg        <= s_acc;
            p1_tag_reg.valid <= issue;

            if (state_reg == ST_CLR) begin
                // sweep all stores back to zero, drop stale forwarding words
                clr_cnt_reg  <= clr_cnt_reg + 1'b1;
                max_ref_reg  <= '0;
                max_pred_reg <= '0;
                t_reg        <= '0;
                fw_o_v_reg   <= 1'b0;
                fw_r_v_reg   <= 1'b0;
                fw_p_v_reg   <= 1'b0;
            end else begin
                if (o_we) fw_o_v_reg <= 1'b1;
                if (r_we) fw_r_v_reg <= 1'b1;
                if (p_we) fw_p_v_reg <= 1'b1;
            end

            if (s_acc) begin
                if (in_ref <= LBL_MAX && in_ref > max_ref_reg) max_ref_reg <= in_ref;
                if (in_pred <= LBL_MAX && in_pred > max_pred_reg) max_pred_reg <= in_pred;
            end

            // start of a threshold pass: rewind the walk
            if (state_reg == ST_DRAIN || (state_reg == ST_RES && m_tready
                                          && t_reg != t_last_idx)) begin
                wi_reg         <= LW'(1);
                wj_reg         <= LW'(1);
                issue_done_reg <= walk_empty;
                hits_reg       <= '0;
                tp_reg         <= '0;
                fn_reg         <= '0;
                pmatched_reg   <= '0;
                pm_cnt_reg     <= '0;
            end

            if (state_reg == ST_RES && m_tready && t_reg != t_last_idx) begin
                t_reg <= t_reg + 1'b1;
            end

            // issue one pair per cycle, row by row
            if (issue) begin
                if (wj_reg == max_pred_reg) begin
                    wj_reg <= LW'(1);
                    if (wi_reg == max_ref_reg) begin
                        issue_done_reg <= 1'b1;
                    end else begin
                        wi_reg <= wi_reg + 1'b1;
                    end
                end else begin
                    wj_reg <= wj_reg + 1'b1;
                end
            end

            // fold match results: per-row hit count and predicted-label coverage
            if (p2_tag.valid) begin
                if (p2_tag.j_last) begin
                    hits_reg <= '0;
                    if (hits_sum == 2'd1 && tp_reg != '1) tp_reg <= tp_reg + 1'b1;
                    if (hits_sum == 2'd0 && fn_reg != '1) fn_reg <= fn_reg + 1'b1;
                end else begin
                    hits_reg <= hits_sum;
                end
                if (p2_match && !pmatched_reg[p2_tag.j]) begin
                    pmatched_reg[p2_tag.j] <= 1'b1;
                    pm_cnt_reg <= pm_cnt_reg + 1'b1;
                end
            end

            // hold the result until taken
            if (walk_finish) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, out_fn_reg, out_fp_reg, out_tp_reg};
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = out_last_reg;
endmodule
`default_nettype wire
